// File: rtl/assert_macros.svh
// assertion helpers included by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is active
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/uer_pkg.sv
package uer_pkg;

    // measurement phases
    typedef enum logic [1:0] {
        PH_TRIGGER = 2'd0,
        PH_WAIT    = 2'd1,
        PH_PAUSE   = 2'd2
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] REG_TRIGGER  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;
    localparam logic [1:0] REG_SCALE    = 2'd3;

    // configuration reset values
    localparam logic [7:0]  TRIGGER_RESET  = 8'd4;
    localparam logic [19:0] TIMEOUT_RESET  = 20'd18750;
    localparam logic [19:0] INTERVAL_RESET = 20'd112500;
    localparam logic [15:0] SCALE_RESET    = 16'd2997;

    localparam int COUNT_BITS = 20;
    localparam int OUT_BYTES_BITS = 40;

    // one result item, first field in the highest bits
    typedef struct packed {
        logic [15:0] distance_cm;
        logic [15:0] width_ticks;
        logic        timed_out;
        logic        measure_done;
        logic        trigger_level;
    } result_t;

endpackage

// File: rtl/ultrasonic_echo_ranger_top.sv
// channel   direction  payload
// s_*       in         tdata[0] echo_level, tdata[7:1] zero
// m_*       out        tdata: trigger_level, measure_done, timed_out, width_ticks, distance_cm
// cfg_*     in         cfg_index register index, cfg_data write value
//
// one input tick is taken per clock while s_tready is high and yields one registered result item
// the whole tick update and the width times scale product fit between the input
// handshake and the output register
// rst_n clears phase, counters, stamps and output valids at once
// a two-entry output stage (register plus skid) lets a tick be taken while a
// result waits; s_tready drops only when both entries are full
module ultrasonic_echo_ranger_top #(
    parameter int CAPTURE_BITS    = 16,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] echo_level
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] trigger_level, [1] measure_done, [2] timed_out,
    // [18:3] width_ticks, [34:19] distance_cm
    output logic [uer_pkg::OUT_BYTES_BITS-1:0] m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [19:0]               cfg_data
);
    import uer_pkg::*;

    `include "assert_macros.svh"

    localparam logic [32:0] ROUND_HALF = 33'(1) << (SCALE_FRAC_BITS - 1);

    // configuration registers
    logic [7:0]  trigger_reg;
    logic [19:0] timeout_reg;
    logic [19:0] interval_reg;
    logic [15:0] scale_reg;

    // ranging state
    phase_t                  phase_reg, phase_next;
    logic [COUNT_BITS-1:0]   phase_count_reg, phase_count_next;
    logic [CAPTURE_BITS-1:0] cap_count_reg;
    logic [CAPTURE_BITS-1:0] rise_stamp_reg, rise_stamp_next;
    logic                    awaiting_reg, awaiting_next;
    logic                    last_echo_reg;

    // output stage
    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic                    in_take, out_take;
    logic                    echo, rise, fall;
    logic [COUNT_BITS-1:0]   count_inc;
    logic [CAPTURE_BITS-1:0] diff;
    logic [31:0]             diff_wide;
    logic [15:0]             width_sat;
    logic [31:0]             product;
    logic [32:0]             rounded;
    logic [32:0]             dist_full;
    logic [15:0]             dist_sat;

    // check terms
    logic out_plain, out_both_flags, out_fields_clear, stall_into_skid;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_take   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign out_take  = out_valid_reg && m_tready;
    assign m_tdata   = OUT_BYTES_BITS'(out_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg  <= TRIGGER_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            interval_reg <= INTERVAL_RESET;
            scale_reg    <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TRIGGER:  trigger_reg  <= cfg_data[7:0];
                REG_TIMEOUT:  timeout_reg  <= cfg_data;
                REG_INTERVAL: interval_reg <= cfg_data;
                REG_SCALE:    scale_reg    <= cfg_data[15:0];
                default:      trigger_reg  <= trigger_reg;
            endcase
        end
    end

    // edge detect and echo width arithmetic
    assign echo      = s_tdata[0];
    assign rise      = echo && !last_echo_reg;
    assign fall      = !echo && last_echo_reg;
    assign count_inc = phase_count_reg + COUNT_BITS'(1);
    assign diff      = cap_count_reg - rise_stamp_reg;
    assign diff_wide = 32'(diff);
    assign width_sat = (|diff_wide[31:16]) ? 16'hFFFF : diff_wide[15:0];
    assign product   = 32'(width_sat) * 32'(scale_reg);
    assign rounded   = {1'b0, product} + ROUND_HALF;
    assign dist_full = rounded >> SCALE_FRAC_BITS;
    assign dist_sat  = (|dist_full[32:16]) ? 16'hFFFF : dist_full[15:0];

    // phase sequencing for one tick
    always_comb
    begin
        phase_next       = phase_reg;
        phase_count_next = phase_count_reg;
        rise_stamp_next  = rise_stamp_reg;
        awaiting_next    = awaiting_reg;
        res_next         = '0;
        case (phase_reg)
            PH_WAIT:
            begin
                if (rise && !awaiting_reg)
                begin
                    rise_stamp_next = cap_count_reg;
                    awaiting_next   = 1'b1;
                end
                else if (fall && awaiting_reg)
                begin
                    res_next.measure_done = 1'b1;
                    res_next.width_ticks  = width_sat;
                    res_next.distance_cm  = dist_sat;
                    awaiting_next         = 1'b0;
                end
                if (res_next.measure_done)
                begin
                    phase_next       = PH_PAUSE;
                    phase_count_next = '0;
                end
                else
                begin
                    phase_count_next = count_inc;
                    if (count_inc >= timeout_reg || count_inc == '0)
                    begin
                        res_next.timed_out = 1'b1;
                        phase_next         = PH_PAUSE;
                        phase_count_next   = '0;
                    end
                end
            end
            PH_PAUSE:
            begin
                phase_count_next = count_inc;
                if (count_inc >= interval_reg || count_inc == '0)
                begin
                    phase_next       = PH_TRIGGER;
                    phase_count_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_TRIGGER;
                if (phase_count_reg == '0)
                begin
                    awaiting_next   = 1'b0;
                    rise_stamp_next = '0;
                end
                res_next.trigger_level = 1'b1;
                phase_count_next       = count_inc;
                if (count_inc >= COUNT_BITS'(trigger_reg) || count_inc == '0)
                begin
                    phase_next       = PH_WAIT;
                    phase_count_next = '0;
                end
            end
        endcase
    end

    // state update on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TRIGGER;
            phase_count_reg <= '0;
            cap_count_reg   <= '0;
            rise_stamp_reg  <= '0;
            awaiting_reg    <= 1'b0;
            last_echo_reg   <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg       <= phase_next;
            phase_count_reg <= phase_count_next;
            cap_count_reg   <= cap_count_reg + CAPTURE_BITS'(1);
            rise_stamp_reg  <= rise_stamp_next;
            awaiting_reg    <= awaiting_next;
            last_echo_reg   <= echo;
        end
    end

    // output register and skid entry valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register and skid entry payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
    end

    // checks
    assign out_plain        = out_valid_reg && !out_reg.measure_done;
    assign out_both_flags   = out_reg.measure_done && out_reg.timed_out;
    assign out_fields_clear = (out_reg.width_ticks == 16'd0) && (out_reg.distance_cm == 16'd0);
    assign stall_into_skid  = in_take && out_valid_reg && !m_tready && !skid_valid_reg;

    `ASSERT_ALWAYS(a_skid_needs_out, (skid_valid_reg |-> out_valid_reg), "skid without output")
    `ASSERT_CLK(a_done_xor_timeout, out_valid_reg |-> !out_both_flags, "done with timeout")
    `ASSERT_CLK(a_width_only_done, out_plain |-> out_fields_clear, "width without completion")
    `ASSERT_CLK(a_stall_fills_skid, stall_into_skid |=> skid_valid_reg, "stalled item lost")

endmodule

// File: tb/ultrasonic_echo_ranger_top_test.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top_test;

    import uer_pkg::*;

    // stimulus actions held in the pending queue
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_DRAIN = 2'd2
    } act_t;

    typedef struct {
        act_t        act;
        logic        echo;
        logic [1:0]  idx;
        logic [19:0] value;
    } pending_t;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_TICKS  = 150;
    localparam int LONG_HOLD   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [0] echo_level, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] trigger_level, [1] measure_done, [2] timed_out,
    // [18:3] width_ticks, [34:19] distance_cm
    logic [uer_pkg::OUT_BYTES_BITS-1:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_TRIGGER;
    logic [19:0] cfg_data = '0;

    pending_t    pending[$];
    result_t     expected_readings[$];

    int ticks_total = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int errors = 0;
    int echoes_measured = 0;
    int waits_expired = 0;
    int writes_done = 0;
    int stall_cycles = 0;

    // sender and receiver pacing
    int send_gap = 0;
    int send_calm = 0;
    int recv_gap = 0;
    int recv_calm = 0;
    int long_hold = 0;
    int holds_done = 0;
    logic taken, settled, next_s, next_c, next_r;
    result_t want, got;

    // predictor state and its copy of the registers
    phase_t      cur_phase;
    logic [19:0] phase_ticks;
    logic [15:0] stamp_clock;
    logic [15:0] rise_time;
    logic        fall_armed;
    logic        echo_prev;
    logic [7:0]  cfg_trigger;
    logic [19:0] cfg_timeout;
    logic [19:0] cfg_interval;
    logic [15:0] cfg_scale;

    wire tail_phase = (ticks_sent + TAIL_TICKS >= ticks_total);

    ultrasonic_echo_ranger_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one tick of the ranger: trigger, echo wait or pause
    function automatic result_t ranger_predict(input logic echo);
        result_t     r;
        logic        rise;
        logic        fall;
        logic [15:0] span;
        logic [32:0] scaled;
        r = '0;
        rise = echo && !echo_prev;
        fall = !echo && echo_prev;
        case (cur_phase)
            PH_WAIT:
            begin
                if (rise && !fall_armed)
                begin
                    rise_time = stamp_clock;
                    fall_armed = 1'b1;
                end
                else if (fall && fall_armed)
                begin
                    span = stamp_clock - rise_time;
                    scaled = 33'(span) * 33'(cfg_scale) + 33'd32768;
                    r.width_ticks = span;
                    r.distance_cm = (scaled[32:16] > 17'd65535) ? 16'hFFFF : scaled[31:16];
                    r.measure_done = 1'b1;
                    fall_armed = 1'b0;
                end
                // a completed echo wins over an expiring wait
                if (r.measure_done)
                begin
                    cur_phase = PH_PAUSE;
                    phase_ticks = '0;
                    echoes_measured++;
                end
                else
                begin
                    phase_ticks = phase_ticks + 20'd1;
                    if (phase_ticks >= cfg_timeout || phase_ticks == 20'd0)
                    begin
                        r.timed_out = 1'b1;
                        cur_phase = PH_PAUSE;
                        phase_ticks = '0;
                        waits_expired++;
                    end
                end
            end
            PH_PAUSE:
            begin
                phase_ticks = phase_ticks + 20'd1;
                if (phase_ticks >= cfg_interval || phase_ticks == 20'd0)
                begin
                    cur_phase = PH_TRIGGER;
                    phase_ticks = '0;
                end
            end
            default:
            begin
                cur_phase = PH_TRIGGER;
                if (phase_ticks == 20'd0)
                begin
                    fall_armed = 1'b0;
                    rise_time = '0;
                end
                r.trigger_level = 1'b1;
                phase_ticks = phase_ticks + 20'd1;
                if (phase_ticks >= 20'(cfg_trigger) || phase_ticks == 20'd0)
                begin
                    cur_phase = PH_WAIT;
                    phase_ticks = '0;
                end
            end
        endcase
        echo_prev = echo;
        stamp_clock = stamp_clock + 16'd1;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    task automatic queue_tick(input logic echo);
        pending_t p;
        p = '{act: ACT_TICK, echo: echo, idx: REG_TRIGGER, value: '0};
        pending.push_back(p);
        ticks_total++;
    endtask

    task automatic queue_write(input logic [1:0] idx, input logic [19:0] value);
        pending_t p;
        p = '{act: ACT_WRITE, echo: 1'b0, idx: idx, value: value};
        pending.push_back(p);
    endtask

    task automatic queue_drain();
        pending_t p;
        p = '{act: ACT_DRAIN, echo: 1'b0, idx: REG_TRIGGER, value: '0};
        pending.push_back(p);
    endtask

    // echo pin as alternating runs, optionally with single-tick glitches
    task automatic queue_echo_train(input int count, input int max_run, input int noise_pct);
        logic level;
        int   run;
        level = 1'($urandom_range(0, 1));
        while (count > 0)
        begin
            run = $urandom_range(1, max_run);
            while (run > 0 && count > 0)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                    queue_tick(1'($urandom_range(0, 1)));
                else
                    queue_tick(level);
                run--;
                count--;
            end
            level = !level;
        end
    endtask

    // prediction on every accepted tick and register write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_phase = PH_TRIGGER;
            phase_ticks = '0;
            stamp_clock = '0;
            rise_time = '0;
            fall_armed = 1'b0;
            echo_prev = 1'b0;
            cfg_trigger = TRIGGER_RESET;
            cfg_timeout = TIMEOUT_RESET;
            cfg_interval = INTERVAL_RESET;
            cfg_scale = SCALE_RESET;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_readings.push_back(ranger_predict(s_tdata[0]));
            if (cfg_valid && cfg_ready)
            begin
                writes_done++;
                case (cfg_index)
                    REG_TRIGGER:  cfg_trigger = cfg_data[7:0];
                    REG_TIMEOUT:  cfg_timeout = cfg_data;
                    REG_INTERVAL: cfg_interval = cfg_data;
                    REG_SCALE:    cfg_scale = cfg_data[15:0];
                    default:      ;
                endcase
            end
        end
    end

    // driver: ticks and register writes from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            cfg_valid <= 1'b0;
            cfg_index <= REG_TRIGGER;
            cfg_data <= '0;
            ticks_sent <= 0;
        end
        else
        begin
            taken = s_tvalid && s_tready;
            settled = (ticks_sent + (taken ? 1 : 0)) == results_seen;
            next_s = 1'b0;
            next_c = 1'b0;
            if (taken)
                ticks_sent <= ticks_sent + 1;
            if ((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready))
            begin
                // offer stays until taken
                next_s = s_tvalid;
                next_c = cfg_valid;
            end
            else if (send_gap > 0)
                send_gap--;
            else if (pending.size() != 0)
            begin
                case (pending[0].act)
                    ACT_TICK:
                    begin
                        if (!tail_phase && send_calm == 0 && $urandom_range(0, 7) == 0)
                            send_gap = $urandom_range(1, 17) - 1;
                        else
                        begin
                            if (send_calm > 0)
                                send_calm--;
                            else if ($urandom_range(0, 39) == 0)
                                send_calm = $urandom_range(20, 80);
                            next_s = 1'b1;
                            s_tdata <= {7'b0, pending[0].echo};
                            void'(pending.pop_front());
                        end
                    end
                    ACT_WRITE:
                    begin
                        // registers change only with nothing in flight
                        if (settled)
                        begin
                            next_c = 1'b1;
                            cfg_index <= pending[0].idx;
                            cfg_data <= pending[0].value;
                            void'(pending.pop_front());
                        end
                    end
                    default:
                    begin
                        if (settled)
                            void'(pending.pop_front());
                    end
                endcase
            end
            s_tvalid <= next_s;
            cfg_valid <= next_c;
        end
    end

    // monitor: result checking and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            results_seen <= 0;
            long_hold <= 0;
            holds_done <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_readings.size() == 0)
                begin
                    $error("result item with no expected reading");
                    errors++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    got = result_t'(m_tdata[$bits(result_t)-1:0]);
                    check_field("trigger_level", want.trigger_level, got.trigger_level);
                    check_field("measure_done", want.measure_done, got.measure_done);
                    check_field("timed_out", want.timed_out, got.timed_out);
                    check_field("width_ticks", want.width_ticks, got.width_ticks);
                    check_field("distance_cm", want.distance_cm, got.distance_cm);
                end
            end
            next_r = 1'b0;
            if (long_hold > 0)
                long_hold <= long_hold - 1;
            else if (holds_done < 2 && results_seen >= 500 + 800 * holds_done)
            begin
                // long hold-off so the output stage fills and stalls the input
                holds_done <= holds_done + 1;
                long_hold <= LONG_HOLD;
            end
            else if (recv_gap > 0)
                recv_gap--;
            else if (!tail_phase && recv_calm == 0 && $urandom_range(0, 5) == 0)
                recv_gap = $urandom_range(1, 17) - 1;
            else
            begin
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 39) == 0)
                    recv_calm = $urandom_range(20, 80);
                next_r = 1'b1;
            end
            m_tready <= next_r;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [19:0] t, w, p, s;
        int          n, max_run, noise;

        // reset settings: edges in trigger ignored, fall without rise, one echo
        queue_tick(1'b0);
        repeat (4) queue_tick(1'b1);
        repeat (2) queue_tick(1'b0);
        repeat (3) queue_tick(1'b1);
        queue_tick(1'b0);
        // edges during the pause
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        // zero registers act as one tick, upper data bits are masked
        queue_write(REG_TRIGGER, 20'hFFF00);
        queue_write(REG_TIMEOUT, 20'h00000);
        queue_write(REG_INTERVAL, 20'h00000);
        queue_write(REG_SCALE, 20'hFFFFF);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b0);
        queue_tick(1'b1);

        // random phases, each with its own register settings
        for (int k = 0; k < 14; k++)
        begin
            if (k == 0)
            begin
                t = 20'd255;
                w = 20'hFFFFF;
                p = 20'd1;
                s = 20'hFFFF;
                n = 400;
                max_run = 150;
                noise = 0;
            end
            else if (k == 1)
            begin
                t = 20'd1;
                w = 20'd1;
                p = 20'hFFFFF;
                s = 20'd0;
                n = 40;
                max_run = 4;
                noise = 0;
            end
            else if (k == 2)
            begin
                t = 20'd0;
                w = 20'd0;
                p = 20'd0;
                s = 20'd1;
                n = 100;
                max_run = 3;
                noise = 10;
            end
            else
            begin
                t = 20'($urandom_range(1, 4));
                w = 20'($urandom_range(1, 40));
                p = 20'($urandom_range(1, 8));
                s = 20'($urandom_range(0, 65535));
                n = 130;
                max_run = $urandom_range(1, w / 2 + 3);
                noise = (k % 4 == 3) ? 30 : 2;
            end
            queue_write(REG_TRIGGER, (20'($urandom) & 20'hFFF00) | t);
            queue_write(REG_TIMEOUT, w);
            queue_write(REG_INTERVAL, p);
            queue_write(REG_SCALE, (20'($urandom) & 20'hF0000) | s);
            queue_echo_train(n / 2, max_run, noise);
            // sender waits for every result now and then
            if ($urandom_range(0, 1) == 0)
                queue_drain();
            queue_echo_train(n - n / 2, max_run, noise);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_tvalid || cfg_valid || ticks_sent != results_seen)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_readings.size() != 0)
        begin
            $error("%0d expected readings never arrived", expected_readings.size());
            errors++;
        end
        $display("checked %0d ticks over %0d register writes", ticks_sent, writes_done);
        $display("echoes measured %0d, waits expired %0d", echoes_measured, waits_expired);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
